FILE: src/ctcg_pkg.sv
// shared types and constants of the ctc greedy decoder
package ctcg_pkg;

  // configuration register widths
  localparam int CLASSES_W    = 9;
  localparam int STEP_COUNT_W = 7;
  localparam int VOCAB_W      = 8;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 9;

  // fixed result field widths
  localparam int SYM_INDEX_W  = 8;
  localparam int CHAR_TOTAL_W = 7;

  // register indexes on the configuration channel
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CLASSES    = 2'd0,
    REG_STEP_COUNT = 2'd1,
    REG_VOCAB      = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_index_t;

  // register values after reset
  localparam logic [CLASSES_W-1:0]    CLASSES_RST    = 9'd69;
  localparam logic [STEP_COUNT_W-1:0] STEP_COUNT_RST = 7'd40;
  localparam logic [VOCAB_W-1:0]      VOCAB_RST      = 8'd68;

  // configuration as seen by the front and back parts
  typedef struct packed {
    logic [CLASSES_W-1:0]    n_classes;
    logic [STEP_COUNT_W-1:0] step_count;
    logic [VOCAB_W-1:0]      vocab_len;
  } cfg_t;

endpackage

FILE: src/ctc_greedy_decoder_unit.sv
// CTC greedy decoder: streamed class scores in, character indices and a sequence summary out
//
// Scores arrive one per transaction, classes in order within each time step. The front part
// keeps the running argmax and takes one score per cycle as long as its four-entry step queue
// has room. The back part takes one finished step per cycle while it is idle and its result
// register is free, drops blanks, repeats and indices at or above the vocabulary size, and
// registers each character result. At the end of a sequence the mean score is found by a
// restoring divider giving one quotient bit per cycle over the SCORE_WIDTH + clog2(MAX_STEPS+1)
// bit score sum. The back part stays busy through the division, if any, and the summary on a
// sequence end, and the queue absorbs four steps meanwhile: with at least six classes per
// step, sequences of at least 24 scores more than they have steps, and a free result consumer
// the front never waits; shorter steps or sequences stall the input at each sequence end.
// The user must write registers through the configuration channel only while the block is
// idle; the block itself does not enforce this.
module ctc_greedy_decoder_unit import ctcg_pkg::*; #(
  parameter int MAX_CLASSES = 256,
  parameter int MAX_STEPS   = 64,
  parameter int SCORE_WIDTH = 16,
  localparam int IN_W  = ((SCORE_WIDTH + 7) / 8) * 8,
  localparam int FLD_W = SYM_INDEX_W + CHAR_TOTAL_W + 2 * SCORE_WIDTH,
  localparam int OUT_W = ((FLD_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // score stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_W-1:0]        s_axis_tdata,  // score, zero padding
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_W-1:0]       m_axis_tdata,  // sym_index, char_score, char_total, mean_score, padding
  output logic                   m_axis_tuser,  // is_summary
  output logic                   m_axis_tlast
);

  localparam int CLS_W = $clog2(MAX_CLASSES);
  localparam int EV_W  = CLS_W + SCORE_WIDTH + 1;
  localparam int PAD_W = OUT_W - FLD_W;

  cfg_t                          cfg;
  logic                          q_full;
  logic                          q_empty;
  logic                          q_pop;
  logic                          ev_push;
  logic [CLS_W-1:0]              ev_class_w;
  logic signed [SCORE_WIDTH-1:0] ev_score_w;
  logic                          ev_seq_end_w;
  logic [EV_W-1:0]               q_wr;
  logic [EV_W-1:0]               q_rd;
  logic [SYM_INDEX_W-1:0]        out_index;
  logic [SCORE_WIDTH-1:0]        out_score;
  logic [CHAR_TOTAL_W-1:0]       out_total;
  logic [SCORE_WIDTH-1:0]        out_mean;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.n_classes  <= CLASSES_RST;
      cfg.step_count <= STEP_COUNT_RST;
      cfg.vocab_len  <= VOCAB_RST;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_CLASSES:    cfg.n_classes  <= cfg_data[CLASSES_W-1:0];
        REG_STEP_COUNT: cfg.step_count <= cfg_data[STEP_COUNT_W-1:0];
        REG_VOCAB:      cfg.vocab_len  <= cfg_data[VOCAB_W-1:0];
        default: ;
      endcase
    end
  end

  // argmax front
  ctcg_front #(
    .MAX_CLASSES (MAX_CLASSES),
    .MAX_STEPS   (MAX_STEPS),
    .SCORE_WIDTH (SCORE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_score   (s_axis_tdata[SCORE_WIDTH-1:0]),
    .q_full     (q_full),
    .ev_push    (ev_push),
    .ev_class   (ev_class_w),
    .ev_score   (ev_score_w),
    .ev_seq_end (ev_seq_end_w)
  );

  // step event queue
  assign q_wr = {ev_seq_end_w, ev_score_w, ev_class_w};

  ctcg_queue #(
    .WIDTH (EV_W),
    .DEPTH (4)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (ev_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  // filtering, accumulation and result back end
  ctcg_back #(
    .MAX_CLASSES (MAX_CLASSES),
    .MAX_STEPS   (MAX_STEPS),
    .SCORE_WIDTH (SCORE_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .vocab_len   (cfg.vocab_len),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .ev_class    (q_rd[CLS_W-1:0]),
    .ev_score    (q_rd[CLS_W+SCORE_WIDTH-1:CLS_W]),
    .ev_seq_end  (q_rd[EV_W-1]),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_summary (m_axis_tuser),
    .out_index   (out_index),
    .out_score   (out_score),
    .out_total   (out_total),
    .out_mean    (out_mean),
    .out_last    (m_axis_tlast)
  );

  // result packing, first field lowest
  assign m_axis_tdata = {{PAD_W{1'b0}}, out_mean, out_total, out_score, out_index};

endmodule

FILE: src/ctcg_queue.sv
// small register queue carrying step events from the front to the back part
module ctcg_queue import ctcg_pkg::*; #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      fill;

  assign full    = (fill == (AW+1)'(DEPTH));
  assign empty   = (fill == '0);
  assign rd_data = slots[rd_ptr];

  // pointer and fill tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (AW+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (AW+1)'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue read while empty");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (fill != '0))
    else $error("queue fill lost a transaction");

endmodule

FILE: src/ctcg_front.sv
// front part: running argmax over the classes of each time step
module ctcg_front import ctcg_pkg::*; #(
  parameter int MAX_CLASSES = 256,
  parameter int MAX_STEPS   = 64,
  parameter int SCORE_WIDTH = 16,
  localparam int CLS_W = $clog2(MAX_CLASSES)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SCORE_WIDTH-1:0] in_score,
  input  logic                          q_full,
  output logic                          ev_push,
  output logic [CLS_W-1:0]              ev_class,
  output logic signed [SCORE_WIDTH-1:0] ev_score,
  output logic                          ev_seq_end
);

  localparam int CCW   = (CLS_W + 1 > CLASSES_W) ? CLS_W + 1 : CLASSES_W;
  localparam int STP_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int SCW   = (STP_W + 1 > STEP_COUNT_W) ? STP_W + 1 : STEP_COUNT_W;

  logic [CLS_W-1:0]              class_pos;
  logic [STP_W-1:0]              step_pos;
  logic signed [SCORE_WIDTH-1:0] best_score;
  logic [CLS_W-1:0]              best_class;

  logic [CCW-1:0]                nc_raw;
  logic [CCW-1:0]                nc;
  logic [SCW-1:0]                ns_raw;
  logic [SCW-1:0]                ns;
  logic                          accept;
  logic                          step_end;
  logic                          seq_end;
  logic signed [SCORE_WIDTH-1:0] cur_score;
  logic [CLS_W-1:0]              cur_class;

  // limits clamped into their legal range
  always_comb begin
    nc_raw = CCW'(cfg.n_classes);
    ns_raw = SCW'(cfg.step_count);
    if (nc_raw == '0) begin
      nc = CCW'(1);
    end else if (nc_raw > CCW'(MAX_CLASSES)) begin
      nc = CCW'(MAX_CLASSES);
    end else begin
      nc = nc_raw;
    end
    if (ns_raw == '0) begin
      ns = SCW'(1);
    end else if (ns_raw > SCW'(MAX_STEPS)) begin
      ns = SCW'(MAX_STEPS);
    end else begin
      ns = ns_raw;
    end
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  // argmax update, first maximum wins
  always_comb begin
    if (class_pos == '0) begin
      cur_score = in_score;
      cur_class = '0;
    end else if (in_score > best_score) begin
      cur_score = in_score;
      cur_class = class_pos;
    end else begin
      cur_score = best_score;
      cur_class = best_class;
    end
  end

  assign step_end = (CCW'(class_pos) + CCW'(1)) >= nc;
  assign seq_end  = (SCW'(step_pos) + SCW'(1)) >= ns;

  assign ev_push    = accept && step_end;
  assign ev_class   = cur_class;
  assign ev_score   = cur_score;
  assign ev_seq_end = seq_end;

  // class and step position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      class_pos <= '0;
      step_pos  <= '0;
    end else if (accept) begin
      class_pos <= step_end ? '0 : class_pos + CLS_W'(1);
      if (step_end) begin
        step_pos <= seq_end ? '0 : step_pos + STP_W'(1);
      end
    end
  end

  // running best of the current step
  always_ff @(posedge clk) begin
    if (accept) begin
      best_score <= cur_score;
      best_class <= cur_class;
    end
  end

endmodule

FILE: src/ctcg_back.sv
// back part: repeat and blank filtering, score accumulation, mean divider, result register
module ctcg_back import ctcg_pkg::*; #(
  parameter int MAX_CLASSES = 256,
  parameter int MAX_STEPS   = 64,
  parameter int SCORE_WIDTH = 16,
  localparam int CLS_W = $clog2(MAX_CLASSES)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [VOCAB_W-1:0]            vocab_len,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  logic [CLS_W-1:0]              ev_class,
  input  logic signed [SCORE_WIDTH-1:0] ev_score,
  input  logic                          ev_seq_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_summary,
  output logic [SYM_INDEX_W-1:0]        out_index,
  output logic [SCORE_WIDTH-1:0]        out_score,
  output logic [CHAR_TOTAL_W-1:0]       out_total,
  output logic [SCORE_WIDTH-1:0]        out_mean,
  output logic                          out_last
);

  localparam int CNT_W  = $clog2(MAX_STEPS + 1);
  localparam int SUM_W  = SCORE_WIDTH + CNT_W;
  localparam int DIV_W  = $clog2(SUM_W);
  localparam int VW     = (CLS_W > VOCAB_W) ? CLS_W : VOCAB_W;
  localparam int TOT_XW = (CNT_W > CHAR_TOTAL_W) ? CNT_W : CHAR_TOTAL_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_SUM  = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [CLS_W-1:0]  prev_class;
  logic              prev_valid;
  logic [SUM_W-1:0]  acc_sum;
  logic [CNT_W-1:0]  emitted_count;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic              div_neg;
  logic [DIV_W-1:0]  div_step;

  logic              out_free;
  logic [VW-1:0]     char_idx;
  logic              emit;
  logic [SUM_W-1:0]  sum_next;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W:0]    rem_sh;
  logic              rem_ge;
  logic [SUM_W-1:0]  quo_signed;
  logic              load_summary;
  logic [TOT_XW-1:0] total_ext;

  assign out_free = !out_valid || out_ready;
  assign q_pop    = (state == ST_IDLE) && !q_empty && out_free;

  // blank, repeat and vocabulary checks on the popped step
  assign char_idx = VW'(ev_class) - VW'(1);
  assign emit     = (ev_class != '0) && (!prev_valid || (ev_class != prev_class)) &&
                    (char_idx < VW'(vocab_len));

  assign sum_next   = emit ? acc_sum + {{(SUM_W - SCORE_WIDTH){ev_score[SCORE_WIDTH-1]}},
                                        ev_score}
                           : acc_sum;
  assign count_next = emit ? emitted_count + CNT_W'(1) : emitted_count;

  // one quotient bit per cycle, restoring
  assign rem_sh = {rem, quo[SUM_W-1]};
  assign rem_ge = rem_sh >= (CNT_W+1)'(emitted_count);

  assign quo_signed   = div_neg ? (~quo + SUM_W'(1)) : quo;
  assign load_summary = (state == ST_SUM) && out_free;
  assign total_ext    = TOT_XW'(emitted_count);

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_pop && ev_seq_end) begin
          state_next = (count_next == '0) ? ST_SUM : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_step == DIV_W'(SUM_W - 1)) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control state and sequence accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      prev_valid    <= 1'b0;
      acc_sum       <= '0;
      emitted_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        prev_valid    <= 1'b1;
        acc_sum       <= sum_next;
        emitted_count <= count_next;
      end else if (load_summary) begin
        prev_valid    <= 1'b0;
        acc_sum       <= '0;
        emitted_count <= '0;
      end
      if ((q_pop && emit) || load_summary) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // divider datapath and previous argmax
  always_ff @(posedge clk) begin
    if (q_pop) begin
      prev_class <= ev_class;
      div_neg    <= sum_next[SUM_W-1];
      quo        <= sum_next[SUM_W-1] ? (~sum_next + SUM_W'(1)) : sum_next;
      rem        <= '0;
      div_step   <= '0;
    end else if (state == ST_DIV) begin
      rem      <= rem_ge ? CNT_W'(rem_sh - (CNT_W+1)'(emitted_count)) : rem_sh[CNT_W-1:0];
      quo      <= {quo[SUM_W-2:0], rem_ge};
      div_step <= div_step + DIV_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      out_summary <= 1'b0;
      out_index   <= char_idx[SYM_INDEX_W-1:0];
      out_score   <= ev_score;
      out_total   <= '0;
      out_mean    <= '0;
      out_last    <= 1'b0;
    end else if (load_summary) begin
      out_summary <= 1'b1;
      out_index   <= '0;
      out_score   <= '0;
      out_total   <= total_ext[CHAR_TOTAL_W-1:0];
      out_mean    <= (emitted_count == '0) ? '0 : quo_signed[SCORE_WIDTH-1:0];
      out_last    <= 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    emitted_count <= CNT_W'(MAX_STEPS))
    else $error("character count beyond the step limit");

  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |=> (state == ST_DIV || state == ST_SUM))
    else $error("divider left without a summary");

  a_clear_after_summary: assert property (@(posedge clk) disable iff (rst)
    load_summary |=> (acc_sum == '0 && emitted_count == '0 && !prev_valid))
    else $error("sequence state not cleared after summary");

  a_last_is_summary: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |-> out_summary)
    else $error("last flag on a character result");

endmodule
